### rtl/wildcard_pattern_matcher_top_defines.svh
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_top_defines
// Assertion macros of the glob matcher top-level RTL
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_TOP_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define WPM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpm check failed");

// next-cycle implication, clocked on clk, off during reset
`define WPM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpm check failed");

`endif

### rtl/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared constants and types of the streaming glob matcher
// ----------------------------------------------------------------------------
package wpm_pkg;

  // pattern geometry
  localparam int MAX_PATTERN = 16;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int CHAR_W      = 8;
  localparam int PAT_BITS    = 128;

  // wildcard codes
  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_PAT_LO  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT_HI  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAT_LEN = 2'd2;

  // signals passed from one cell to the next
  typedef struct packed {
    logic cur;   // closed prefix match of the current vector
    logic cls;   // closed prefix match of the captured result vector
  } link_t;

  // per-beat control broadcast to all cells
  typedef struct packed {
    logic step;     // input beat accepted
    logic restart;  // accepted beat ends the text
  } ctl_t;

endpackage

### rtl/wpm_ifs.sv
// ----------------------------------------------------------------------------
// wpm_ifs
// Valid/ready stream interfaces for text bytes and match results
// ----------------------------------------------------------------------------
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink (input valid, input text_char, input last_char, output ready);
endinterface

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic end_of_text;

  modport source (output valid, output matched, output end_of_text, input ready);
  modport sink (input valid, input matched, input end_of_text, output ready);
endinterface

### rtl/wildcard_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_top
// Streaming glob matcher built from a row of pattern-position cells
// ----------------------------------------------------------------------------
// Text enters on in_stream one byte per beat, last_char marking the final
// byte of a text. Each input beat yields exactly one beat on out_stream:
// matched tells whether the text so far matches the whole pattern, and
// end_of_text echoes last_char. The pattern (two 64-bit character words and
// a length) is to be written over the APB port at byte addresses 0, 8 and 16
// only while no beat is in flight; the block itself does not enforce this.
// Throughput is one byte per cycle while out_stream is not stalled. On
// input acceptance the cell row updates the match vector and the result
// copies; the star closure of the result then ripples through the same
// cells into the output register, which sets output valid.
// When the receiver stalls, one result waits in the output register and a
// second in the cells' result copies; input is still taken until both are
// occupied. Reset clears the pattern registers and in-flight beats and sets
// the vector to the empty-prefix match; the block is ready right after.
// ----------------------------------------------------------------------------
`include "wildcard_pattern_matcher_top_defines.svh"

module wildcard_pattern_matcher_top (
  input  logic                           clk,
  input  logic                           rst_n,
  wpm_in_if.sink                         in_stream,
  wpm_out_if.source                      out_stream,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wpm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wpm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wpm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int MAXP = wpm_pkg::MAX_PATTERN;
  localparam int LW   = wpm_pkg::LEN_W;

  logic [wpm_pkg::CFG_DATA_W-1:0] pat_lo_r, pat_lo_nxt;
  logic [wpm_pkg::CFG_DATA_W-1:0] pat_hi_r, pat_hi_nxt;
  logic [LW-1:0]                  pat_len_r, pat_len_nxt;
  logic [wpm_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                           cfg_wr;
  logic [LW-1:0]                  eff_len;
  logic [wpm_pkg::PAT_BITS-1:0]   pat_all;

  logic head_r, head_nxt;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_last_r;
  logic out_valid_r, out_valid_nxt;
  logic out_matched_r;
  logic out_eot_r;
  logic out_load;
  logic in_ready;
  logic accept;

  wpm_pkg::ctl_t  ctl;
  wpm_pkg::link_t link [0:MAXP];

  // apb register decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[wpm_pkg::CFG_ADDR_W-1:3];

  always_comb begin
    pat_lo_nxt  = pat_lo_r;
    pat_hi_nxt  = pat_hi_r;
    pat_len_nxt = pat_len_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        wpm_pkg::REG_PAT_LO:  pat_lo_nxt  = pwdata;
        wpm_pkg::REG_PAT_HI:  pat_hi_nxt  = pwdata;
        wpm_pkg::REG_PAT_LEN: pat_len_nxt = pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= '0;
    end else begin
      pat_lo_r  <= pat_lo_nxt;
      pat_hi_r  <= pat_hi_nxt;
      pat_len_r <= pat_len_nxt;
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_idx)
      wpm_pkg::REG_PAT_LO:  prdata = pat_lo_r;
      wpm_pkg::REG_PAT_HI:  prdata = pat_hi_r;
      wpm_pkg::REG_PAT_LEN: prdata = {{(wpm_pkg::CFG_DATA_W-LW){1'b0}}, pat_len_r};
      default:              prdata = '0;
    endcase
  end

  // saturated pattern length and flat character word
  assign eff_len = (pat_len_r > LW'(MAXP)) ? LW'(MAXP) : pat_len_r;
  assign pat_all = {pat_hi_r, pat_lo_r};

  // two-stage handshake: cell update, then closure into output register
  assign out_load = s1_valid_r & (~out_valid_r | out_stream.ready);
  assign in_ready = ~s1_valid_r | out_load;
  assign accept   = in_stream.valid & in_ready;

  assign in_stream.ready = in_ready;
  assign ctl.step        = accept;
  assign ctl.restart     = in_stream.last_char;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // empty-prefix bit: set at reset and after the last byte of a text
  always_comb begin
    head_nxt = head_r;
    if (accept) begin
      head_nxt = in_stream.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload of both stages
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r <= in_stream.last_char;
    end
    if (out_load) begin
      out_matched_r <= link[eff_len].cls;
      out_eot_r     <= s1_last_r;
    end
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.matched     = out_matched_r;
  assign out_stream.end_of_text = out_eot_r;

  // cell row, position j holds prefix length j+1
  assign link[0].cur = head_r;
  assign link[0].cls = 1'b0;

  for (genvar g = 0; g < MAXP; g++) begin : g_cell
    localparam logic [LW-1:0] POS = LW'(g);
    wpm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .pat_char  (pat_all[wpm_pkg::CHAR_W*g +: wpm_pkg::CHAR_W]),
      .active    (POS < eff_len),
      .text_char (in_stream.text_char),
      .ctl       (ctl),
      .link_in   (link[g]),
      .link_out  (link[g+1])
    );
  end

  // checks
  `WPM_ASSERT_NXT(a_head_restart, accept && in_stream.last_char, head_r)
  `WPM_ASSERT_NXT(a_head_clear, accept && !in_stream.last_char, !head_r)
  `WPM_ASSERT_NXT(a_stage_hold, s1_valid_r && !out_load, s1_valid_r)
  `WPM_ASSERT_IMP(a_ready_free, !s1_valid_r, in_ready)

endmodule

### rtl/wpm_cell.sv
// ----------------------------------------------------------------------------
// wpm_cell
// One pattern position: holds its prefix match bit and a result copy
// ----------------------------------------------------------------------------
module wpm_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [wpm_pkg::CHAR_W-1:0] pat_char,
  input  logic                       active,
  input  logic [wpm_pkg::CHAR_W-1:0] text_char,
  input  wpm_pkg::ctl_t              ctl,
  input  wpm_pkg::link_t             link_in,
  output wpm_pkg::link_t             link_out
);

  logic match_r;
  logic match_nxt;
  logic res_r;
  logic is_star;
  logic is_hit;
  logic cur_closed;
  logic upd;

  // pattern character decode
  assign is_star = (pat_char == wpm_pkg::STAR_CHAR);
  assign is_hit  = (pat_char == wpm_pkg::ANY_CHAR) || (pat_char == text_char);

  // star closure of the stored vector, rippled from the left neighbor
  assign cur_closed = match_r | (active & is_star & link_in.cur);

  // advance by one text byte
  assign upd = active & (is_star ? cur_closed : (is_hit & link_in.cur));

  // state bit, cleared at end of text
  always_comb begin
    match_nxt = match_r;
    if (ctl.step) begin
      match_nxt = ctl.restart ? 1'b0 : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  // result copy for the closure stage
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      res_r <= upd;
    end
  end

  // neighbor hand-off
  assign link_out.cur = cur_closed;
  assign link_out.cls = res_r | (active & is_star & link_in.cls);

endmodule
